// ===== rtl/blc_pkg.sv =====
// Shared constants, types and the tanh table generator for the bubble lift coefficient core.
package blc_pkg;

  localparam int unsigned TANH_TABLE_BITS = 10;
  localparam int unsigned TANH_DEPTH      = 1 << TANH_TABLE_BITS;
  localparam int unsigned TANH_W          = 11;

  localparam int unsigned RE_W     = 24;  // Re, unsigned Q16.8
  localparam int unsigned EO_W     = 23;  // Eo, unsigned Q7.16, up to 64.0
  localparam int unsigned RE_DEN_W = 34;  // 16000 * mu
  localparam int unsigned EO_DEN_W = 44;  // 16e6 * sigma
  localparam int unsigned RE_NUM_W = 56;
  localparam int unsigned EO_NUM_W = 72;
  localparam int unsigned DIV_STEPS = 25;
  localparam int unsigned CL_W     = 21;
  localparam int unsigned TERM_W   = 28;

  localparam logic [RE_W-1:0]   RE_MAX_RAW    = 24'hFFFF00;
  localparam logic [EO_W-1:0]   EO_MAX_RAW    = 23'h400000;
  localparam logic [23:0]       GRAVITY_RESET = 24'd642908;
  localparam logic [TANH_W-1:0] TANH_SAT_Q12  = 11'd1180;
  localparam logic [12:0]       RE_GAIN_Q16   = 13'd7930;

  localparam logic [14:0] F_C3 = 15'd17616;
  localparam logic [18:0] F_C2 = 19'd266758;
  localparam logic [18:0] F_C1 = 19'd342255;
  localparam logic [22:0] F_C0 = 23'd7952400;

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] EXP_M1_Q30 = 64'd395007543;

  typedef struct packed {
    logic [2:0]  tag;
    logic [15:0] rl;
    logic [15:0] al;
  } side_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_DEPTH];

  // bitwise long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 0.288 * tanh(i * 8 / depth) in Q12
  function automatic logic [TANH_W-1:0] tanh_entry(input logic [63:0] idx);
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] th;
    y    = idx << (34 - TANH_TABLE_BITS);
    n    = y >> 30;
    f    = y & (Q30_ONE - 64'd1);
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * f) >> 30, 64'(k));
      if ((k & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    e = sum;
    for (int k = 0; k < 16; k++) begin
      if (64'(k) < n) e = (e * EXP_M1_Q30) >> 30;
    end
    if (e > Q30_ONE) e = Q30_ONE;
    th = udiv64((Q30_ONE - e) << 30, Q30_ONE + e);
    return TANH_W'(udiv64(th * 64'd1179648 + 64'd500 * Q30_ONE, 64'd1000 * Q30_ONE));
  endfunction

  function automatic tanh_rom_t tanh_rom();
    tanh_rom_t r;
    for (int i = 0; i < TANH_DEPTH; i++) begin
      r[i] = tanh_entry(64'(i));
    end
    return r;
  endfunction

endpackage

// ===== rtl/blc_div_pipe.sv =====
// Pipelined restoring dividers for the Reynolds and Eotvos numbers, one quotient bit per stage.
module blc_div_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  blc_pkg::side_t                      side_i,
  input  logic [blc_pkg::RE_NUM_W-1:0]        re_num_i,
  input  logic [blc_pkg::RE_DEN_W-1:0]        re_den_i,
  input  logic [blc_pkg::EO_NUM_W-1:0]        eo_num_i,
  input  logic [blc_pkg::EO_DEN_W-1:0]        eo_den_i,
  output logic                                valid_o,
  output blc_pkg::side_t                      side_o,
  output logic [blc_pkg::RE_W-1:0]            re_o,
  output logic [blc_pkg::EO_W-1:0]            eo_o,
  output logic                                sat_o
);

  localparam int unsigned N  = blc_pkg::DIV_STEPS;
  localparam int unsigned RW = blc_pkg::RE_DEN_W;
  localparam int unsigned EW = blc_pkg::EO_DEN_W;

  typedef struct packed {
    logic           re_ovf;
    logic           eo_ovf;
    logic [RW-1:0]  re_den;
    logic [RW-1:0]  re_rem;
    logic [N-1:0]   re_low;
    logic [N-1:0]   re_q;
    logic [EW-1:0]  eo_den;
    logic [EW-1:0]  eo_rem;
    logic [N-1:0]   eo_low;
    logic [N-1:0]   eo_q;
    blc_pkg::side_t side;
  } dstage_t;

  logic [N:0] vld_q;
  dstage_t    st_q [N+1];
  dstage_t    s0_d;

  logic [blc_pkg::RE_NUM_W-N-1:0] re_hi;
  logic [blc_pkg::EO_NUM_W-N-1:0] eo_hi;

  // quotient >= 2^N means the clamp applies anyway; zero divisors land here too
  always_comb begin
    re_hi = re_num_i[blc_pkg::RE_NUM_W-1:N];
    eo_hi = eo_num_i[blc_pkg::EO_NUM_W-1:N];
    s0_d.re_ovf = RW'(re_hi) >= re_den_i;
    s0_d.eo_ovf = {{(EW+3-(blc_pkg::EO_NUM_W-N)){1'b0}}, eo_hi} >= {3'b000, eo_den_i};
    s0_d.re_den = re_den_i;
    s0_d.re_rem = RW'(re_hi);
    s0_d.re_low = re_num_i[N-1:0];
    s0_d.re_q   = '0;
    s0_d.eo_den = eo_den_i;
    s0_d.eo_rem = eo_hi[EW-1:0];
    s0_d.eo_low = eo_num_i[N-1:0];
    s0_d.eo_q   = '0;
    s0_d.side   = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= s0_d;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW:0] re_r;
    logic [EW:0] eo_r;
    logic        re_ge;
    logic        eo_ge;
    dstage_t     nxt_d;

    always_comb begin
      re_r  = {st_q[k].re_rem, st_q[k].re_low[N-1]};
      eo_r  = {st_q[k].eo_rem, st_q[k].eo_low[N-1]};
      re_ge = re_r >= {1'b0, st_q[k].re_den};
      eo_ge = eo_r >= {1'b0, st_q[k].eo_den};
      nxt_d        = st_q[k];
      nxt_d.re_rem = re_ge ? RW'(re_r - {1'b0, st_q[k].re_den}) : re_r[RW-1:0];
      nxt_d.eo_rem = eo_ge ? EW'(eo_r - {1'b0, st_q[k].eo_den}) : eo_r[EW-1:0];
      nxt_d.re_low = {st_q[k].re_low[N-2:0], 1'b0};
      nxt_d.eo_low = {st_q[k].eo_low[N-2:0], 1'b0};
      nxt_d.re_q   = {st_q[k].re_q[N-2:0], re_ge};
      nxt_d.eo_q   = {st_q[k].eo_q[N-2:0], eo_ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt_d;
      end
    end
  end

  logic                       re_sat;
  logic                       eo_sat;
  logic                       vld_out_q;
  blc_pkg::side_t             side_out_q;
  logic [blc_pkg::RE_W-1:0]   re_out_q;
  logic [blc_pkg::EO_W-1:0]   eo_out_q;
  logic                       sat_out_q;

  assign re_sat = st_q[N].re_ovf || (st_q[N].re_q > N'(blc_pkg::RE_MAX_RAW));
  assign eo_sat = st_q[N].eo_ovf || (st_q[N].eo_q > N'(blc_pkg::EO_MAX_RAW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_out_q <= st_q[N].side;
      re_out_q   <= re_sat ? blc_pkg::RE_MAX_RAW : st_q[N].re_q[blc_pkg::RE_W-1:0];
      eo_out_q   <= eo_sat ? blc_pkg::EO_MAX_RAW : st_q[N].eo_q[blc_pkg::EO_W-1:0];
      sat_out_q  <= re_sat || eo_sat;
    end
  end

  assign valid_o = vld_out_q;
  assign side_o  = side_out_q;
  assign re_o    = re_out_q;
  assign eo_o    = eo_out_q;
  assign sat_o   = sat_out_q;

endmodule

// ===== rtl/bubble_lift_coefficient_core.sv =====
// Top level of the bubble lift coefficient core: front multipliers, dividers, cubic and tanh.
//
// Usage:
//   Each input transaction on the s_axis channel describes one gas phase in one cell.
//   The core forms Re = rho_l*v*d/mu and Eo = g*|rho_l-rho_g|*d^2/sigma in fixed
//   point, evaluates the cubic f(Eo), and below Eo 4 takes min(0.288*tanh(0.121*Re), f).
//   One result transaction per input leaves on m_axis: Cl (Q8.12) and Cl*rho_l*alpha.
//   Gravity is set through the cfg channel (always ready); write it only while idle.
// Throughput: one transaction per cycle, with no bubbles between items, while nothing stalls.
// Pipeline from input accept to m_axis_tvalid:
//   3 multiply stages, 27 divider stages (one quotient bit per stage, 25 bits),
//   then 6 stages for the Horner cubic, the tanh ROM read, the min and the product.
// Stall: the whole pipeline holds while a result waits with m_axis_tready low;
//   s_axis_tready follows that, so nothing is lost or repeated and bubbles
//   in flight still move forward while the output register is empty.
// Reset: rst_ni clears every valid bit and loads gravity with 9.81 (Q8.16);
//   payload registers are not reset. The tanh ROM is a constant table, no fill needed.
// Saturation: a zero divisor or a clamp of Re (65535) or Eo (64) sets the saturated flag.
module bubble_lift_coefficient_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i,      // gravity, Q8.16
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // liquid_density[15:0], gas_density[31:16], liquid_viscosity[51:32],
  // surface_tension[71:52], relative_velocity[87:72], bubble_diameter[103:88],
  // gas_fraction[119:104]
  input  logic [119:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,    // phase_index[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lift_coefficient[20:0], lift_term[48:21], zero[55:49]
  output logic [55:0]  m_axis_tdata,
  output logic [3:0]   m_axis_tuser     // phase_tag[2:0], saturated[3]
);

  logic en;
  logic [23:0] gravity_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // ---------------- stage A: first products ----------------
  logic [15:0] in_rl, in_rg, in_v, in_d, in_al, in_drho;
  logic [19:0] in_mu, in_sg;

  assign in_rl   = s_axis_tdata[15:0];
  assign in_rg   = s_axis_tdata[31:16];
  assign in_mu   = s_axis_tdata[51:32];
  assign in_sg   = s_axis_tdata[71:52];
  assign in_v    = s_axis_tdata[87:72];
  assign in_d    = s_axis_tdata[103:88];
  assign in_al   = s_axis_tdata[119:104];
  assign in_drho = (in_rl > in_rg) ? (in_rl - in_rg) : (in_rg - in_rl);

  logic                             a_vld_q;
  blc_pkg::side_t                   a_side_q;
  logic [15:0]                      a_d_q;
  logic [31:0]                      a_rv_q, a_dd_q;
  logic [39:0]                      a_gdr_q;
  logic [blc_pkg::RE_DEN_W-1:0]     a_re_den_q;
  logic [blc_pkg::EO_DEN_W-1:0]     a_eo_den_q;

  // ---------------- stage B: numerator products ----------------
  logic                             b_vld_q;
  blc_pkg::side_t                   b_side_q;
  logic [blc_pkg::RE_NUM_W-1:0]     b_re_num_q;
  logic [51:0]                      b_pp_lo_q, b_pp_hi_q;
  logic [blc_pkg::RE_DEN_W-1:0]     b_re_den_q;
  logic [blc_pkg::EO_DEN_W-1:0]     b_eo_den_q;

  // ---------------- stage C: Eo numerator sum ----------------
  logic                             c_vld_q;
  blc_pkg::side_t                   c_side_q;
  logic [blc_pkg::RE_NUM_W-1:0]     c_re_num_q;
  logic [blc_pkg::EO_NUM_W-1:0]     c_eo_num_q;
  logic [blc_pkg::RE_DEN_W-1:0]     c_re_den_q;
  logic [blc_pkg::EO_DEN_W-1:0]     c_eo_den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q   <= '{tag: s_axis_tuser, rl: in_rl, al: in_al};
      a_d_q      <= in_d;
      a_rv_q     <= 32'(in_rl) * 32'(in_v);
      a_dd_q     <= 32'(in_d) * 32'(in_d);
      a_gdr_q    <= 40'(gravity_q) * 40'(in_drho);
      a_re_den_q <= blc_pkg::RE_DEN_W'(in_mu) * blc_pkg::RE_DEN_W'(16000);
      a_eo_den_q <= blc_pkg::EO_DEN_W'(in_sg) * blc_pkg::EO_DEN_W'(16000000);

      b_side_q   <= a_side_q;
      b_re_num_q <= {48'(a_rv_q) * 48'(a_d_q), 8'h00};
      b_pp_lo_q  <= 52'(a_gdr_q[19:0]) * 52'(a_dd_q);
      b_pp_hi_q  <= 52'(a_gdr_q[39:20]) * 52'(a_dd_q);
      b_re_den_q <= a_re_den_q;
      b_eo_den_q <= a_eo_den_q;

      c_side_q   <= b_side_q;
      c_re_num_q <= b_re_num_q;
      c_eo_num_q <= blc_pkg::EO_NUM_W'(b_pp_lo_q) + (blc_pkg::EO_NUM_W'(b_pp_hi_q) << 20);
      c_re_den_q <= b_re_den_q;
      c_eo_den_q <= b_eo_den_q;
    end
  end

  // ---------------- dividers ----------------
  logic                       dv_vld;
  blc_pkg::side_t             dv_side;
  logic [blc_pkg::RE_W-1:0]   dv_re;
  logic [blc_pkg::EO_W-1:0]   dv_eo;
  logic                       dv_sat;

  blc_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (c_vld_q),
    .side_i   (c_side_q),
    .re_num_i (c_re_num_q),
    .re_den_i (c_re_den_q),
    .eo_num_i (c_eo_num_q),
    .eo_den_i (c_eo_den_q),
    .valid_o  (dv_vld),
    .side_o   (dv_side),
    .re_o     (dv_re),
    .eo_o     (dv_eo),
    .sat_o    (dv_sat)
  );

  // ---------------- back end: cubic, tanh, min, product ----------------
  localparam blc_pkg::tanh_rom_t TanhRom = blc_pkg::tanh_rom();
  localparam int unsigned TShift = 27 - blc_pkg::TANH_TABLE_BITS;

  logic                         p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, p5_vld_q, p6_vld_q;
  blc_pkg::side_t               p1_side_q, p2_side_q, p3_side_q, p4_side_q, p5_side_q;
  logic                         p1_sat_q, p2_sat_q, p3_sat_q, p4_sat_q, p5_sat_q, p6_sat_q;
  logic                         p1_lt4_q, p2_lt4_q, p3_lt4_q;
  logic [blc_pkg::EO_W-1:0]     p1_eo_q, p2_eo_q;
  logic signed [21:0]           p1_h1_q;
  logic [36:0]                  p1_tprod_q;
  logic signed [29:0]           p2_h2_q;
  logic [blc_pkg::TANH_W-1:0]   p2_rom_q;
  logic                         p2_over_q;
  logic signed [35:0]           p3_h3_q;
  logic [blc_pkg::TANH_W-1:0]   p3_t_q;
  logic signed [blc_pkg::CL_W-1:0] p4_cl_q, p5_cl_q, p6_cl_q;
  logic [15:0]                  p4_al_q;
  logic signed [36:0]           p5_clrl_q;
  logic [15:0]                  p5_al_q;
  logic [blc_pkg::TERM_W-1:0]   p6_term_q;
  logic [2:0]                   p6_tag_q;

  logic [37:0]                  m1;
  logic signed [45:0]           m2;
  logic signed [53:0]           m3;
  logic signed [blc_pkg::CL_W-1:0] fq12;
  logic signed [blc_pkg::CL_W-1:0] t_s;
  logic signed [55:0]           m_term;

  assign m1     = 38'(blc_pkg::F_C3) * 38'(dv_eo);
  assign m2     = 46'(p1_h1_q) * 46'($signed({1'b0, p1_eo_q}));
  assign m3     = 54'(p2_h2_q) * 54'($signed({1'b0, p2_eo_q}));
  assign fq12   = p3_h3_q[32:12];
  assign t_s    = $signed({{(blc_pkg::CL_W-blc_pkg::TANH_W){1'b0}}, p3_t_q});
  assign m_term = 56'(p5_clrl_q) * 56'($signed({1'b0, p5_al_q}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q  <= dv_side;
      p1_sat_q   <= dv_sat;
      p1_eo_q    <= dv_eo;
      p1_lt4_q   <= (dv_eo[blc_pkg::EO_W-1:18] == '0);
      p1_h1_q    <= $signed({1'b0, m1[36:16]}) - 22'(blc_pkg::F_C2);
      p1_tprod_q <= 37'(dv_re) * 37'(blc_pkg::RE_GAIN_Q16);

      p2_side_q  <= p1_side_q;
      p2_sat_q   <= p1_sat_q;
      p2_eo_q    <= p1_eo_q;
      p2_lt4_q   <= p1_lt4_q;
      p2_h2_q    <= 30'(m2 >>> 16) - 30'(blc_pkg::F_C1);
      p2_rom_q   <= TanhRom[p1_tprod_q[TShift +: blc_pkg::TANH_TABLE_BITS]];
      p2_over_q  <= |p1_tprod_q[36:27];

      p3_side_q  <= p2_side_q;
      p3_sat_q   <= p2_sat_q;
      p3_lt4_q   <= p2_lt4_q;
      p3_h3_q    <= 36'(m3 >>> 16) + 36'(blc_pkg::F_C0);
      p3_t_q     <= p2_over_q ? blc_pkg::TANH_SAT_Q12 : p2_rom_q;

      // tanh branch only below Eo 4
      p4_side_q  <= p3_side_q;
      p4_sat_q   <= p3_sat_q;
      p4_al_q    <= p3_side_q.al;
      p4_cl_q    <= (p3_lt4_q && (t_s < fq12)) ? t_s : fq12;

      p5_side_q  <= p4_side_q;
      p5_sat_q   <= p4_sat_q;
      p5_cl_q    <= p4_cl_q;
      p5_al_q    <= p4_al_q;
      p5_clrl_q  <= 37'(p4_cl_q) * 37'($signed({1'b0, p4_side_q.rl}));

      p6_tag_q   <= p5_side_q.tag;
      p6_sat_q   <= p5_sat_q;
      p6_cl_q    <= p5_cl_q;
      p6_term_q  <= m_term[55:28];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= blc_pkg::GRAVITY_RESET;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gravity_q <= cfg_data_i;
      end
      if (en) begin
        a_vld_q  <= s_axis_tvalid;
        b_vld_q  <= a_vld_q;
        c_vld_q  <= b_vld_q;
        p1_vld_q <= dv_vld;
        p2_vld_q <= p1_vld_q;
        p3_vld_q <= p2_vld_q;
        p4_vld_q <= p3_vld_q;
        p5_vld_q <= p4_vld_q;
        p6_vld_q <= p5_vld_q;
      end
    end
  end

  assign m_axis_tvalid = p6_vld_q;
  assign m_axis_tdata  = {7'b0, p6_term_q, p6_cl_q};
  assign m_axis_tuser  = {p6_sat_q, p6_tag_q};

  // ---------------- assertions ----------------
  a_cl_capped_below_eo4 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p4_vld_q && $past(p3_lt4_q) && $past(en) |-> p4_cl_q <= $signed(21'd1180))
    else $error("Cl above the tanh cap below Eo 4");

  a_eo_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld |-> dv_eo <= blc_pkg::EO_MAX_RAW)
    else $error("Eo beyond clamp");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(p4_cl_q) && $stable(p1_h1_q))
    else $error("pipeline moved during stall");

endmodule

// ===== dv/bubble_lift_coefficient_core_tb.sv =====
// Testbench for the bubble lift coefficient core: self-predicting, stream-level checks.
`timescale 1ns / 1ps

module bubble_lift_coefficient_core_tb;

  typedef struct {
    bit [2:0]  tag;
    bit [15:0] rl;
    bit [15:0] rg;
    bit [19:0] mu;
    bit [19:0] sg;
    bit [15:0] v;
    bit [15:0] d;
    bit [15:0] al;
  } cell_t;

  typedef struct {
    bit [2:0]  tag;
    bit [20:0] cl;
    bit [27:0] term;
    bit        sat;
  } lift_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [23:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  bubble_lift_coefficient_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit [23:0]   gravity_q = blc_pkg::GRAVITY_RESET;
  bit [10:0]   tanh_q12 [1 << blc_pkg::TANH_TABLE_BITS];
  lift_t       lift_expected [$];
  int          mismatches = 0;
  int          burst_left = 0;

  // 0.288*tanh(i*8/depth) in Q12: Taylor series of e^-frac, times e^-1 per integer unit
  function automatic bit [10:0] lift_tanh_q12(longint unsigned i);
    longint unsigned one, y, n, f, sum, term, e, th;
    one  = 64'd1 << 30;
    y    = i << (34 - blc_pkg::TANH_TABLE_BITS);
    n    = y >> 30;
    f    = y & (one - 1);
    sum  = one;
    term = one;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * f) >> 30) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    e = sum;
    for (longint unsigned k = 0; k < n; k++) e = (e * 64'd395007543) >> 30;
    if (e > one) e = one;
    th = ((one - e) << 30) / (one + e);
    return 11'((th * 64'd1179648 + 64'd500 * one) / (64'd1000 * one));
  endfunction

  function automatic lift_t lift_predict(cell_t c);
    lift_t           r;
    bit [63:0]       re;
    bit [71:0]       eo_num, eo_q;
    bit [15:0]       drho;
    longint          acc, cl, t;
    longint unsigned idx;
    r.sat = 1'b0;
    if (c.mu == 0) begin
      re = 64'hFFFF00;
      r.sat = 1'b1;
    end else begin
      re = ((64'(c.rl) * 64'(c.v) * 64'(c.d)) << 8) / (64'd16000 * 64'(c.mu));
      if (re > 64'hFFFF00) begin
        re = 64'hFFFF00;
        r.sat = 1'b1;
      end
    end
    drho = (c.rl > c.rg) ? c.rl - c.rg : c.rg - c.rl;
    if (c.sg == 0) begin
      eo_q = 72'h400000;
      r.sat = 1'b1;
    end else begin
      eo_num = 72'(gravity_q) * 72'(drho) * 72'(c.d) * 72'(c.d);
      eo_q = eo_num / (72'd16000000 * 72'(c.sg));
      if (eo_q > 72'h400000) begin
        eo_q = 72'h400000;
        r.sat = 1'b1;
      end
    end
    // Horner in Q24, each product floored by 16 bits
    acc = 17616;
    acc = ((acc * longint'(eo_q)) >>> 16) - 266758;
    acc = ((acc * longint'(eo_q)) >>> 16) - 342255;
    acc = ((acc * longint'(eo_q)) >>> 16) + 7952400;
    cl  = acc >>> 12;
    if (eo_q < 72'h40000) begin
      idx = (re * 64'd7930) >> (27 - blc_pkg::TANH_TABLE_BITS);
      t = (idx < (1 << blc_pkg::TANH_TABLE_BITS)) ? longint'(tanh_q12[idx]) : 1180;
      if (t < cl) cl = t;
    end
    r.tag  = c.tag;
    r.cl   = 21'(cl);
    r.term = 28'((cl * longint'(c.rl) * longint'(c.al)) >>> 28);
    return r;
  endfunction

  // one input transaction; sender idles for a random gap, possibly none, between bursts of random length
  task automatic send_cell(cell_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tdata  <= {c.al, c.d, c.v, c.sg, c.mu, c.rg, c.rl};
    s_axis_tuser  <= c.tag;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    lift_expected.push_back(lift_predict(c));
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (lift_expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_gravity(bit [23:0] g);
    drain();
    cfg_data_i  <= g;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gravity_q = g;
  endtask

  // full range half the time, otherwise a random magnitude so small values show up
  function automatic bit [19:0] rand_field(int w);
    bit [19:0] x;
    x = 20'($urandom);
    if ($urandom_range(0, 1)) x = x & ((20'd1 << $urandom_range(0, w)) - 20'd1);
    return 20'(x & ((21'd1 << w) - 21'd1));
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.tag = 3'($urandom);
    c.rl  = 16'(rand_field(16));
    c.rg  = 16'(rand_field(16));
    c.mu  = rand_field(20);
    c.sg  = rand_field(20);
    c.v   = 16'(rand_field(16));
    c.d   = 16'(rand_field(16));
    c.al  = 16'(rand_field(16));
    return c;
  endfunction

  // water-like liquid and small bubbles, so Eo mostly stays below 4 and the tanh branch is live
  function automatic cell_t bubbly_cell();
    cell_t c;
    c.tag = 3'($urandom);
    c.rl  = 16'($urandom_range(8000, 20000));
    c.rg  = 16'($urandom_range(0, 400));
    c.mu  = 20'($urandom_range(200, 5000));
    c.sg  = 20'($urandom_range(20000, 100000));
    c.v   = 16'($urandom_range(0, 400));
    c.d   = 16'($urandom_range(0, 6000));
    c.al  = 16'($urandom);
    return c;
  endfunction

  // receiver: changes stall behavior at random intervals; in one mode it never stalls
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    lift_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lift_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: tdata %h tuser %h",
                                       m_axis_tdata, m_axis_tuser);
      end else begin
        want = lift_expected.pop_front();
        if (m_axis_tuser[2:0] != want.tag || m_axis_tdata[20:0] != want.cl ||
            m_axis_tdata[48:21] != want.term || m_axis_tuser[3] != want.sat ||
            m_axis_tdata[55:49] != 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %h %0d, got %0d %h %h %0d pad %h",
                     want.tag, want.cl, want.term, want.sat, m_axis_tuser[2:0],
                     m_axis_tdata[20:0], m_axis_tdata[48:21], m_axis_tuser[3],
                     m_axis_tdata[55:49]);
        end
      end
    end
  end

  task automatic test_special_cases();
    cell_t c;
    c = '{3'd0, 16'd16000, 16'd16, 20'd1000, 20'd72000, 16'd10, 16'd100, 16'd32768};
    send_cell(c);                               // tiny Re, tiny Eo: tanh in table
    c.tag = 3'd1; c.v = 16'd50; c.d = 16'd1000;
    send_cell(c);                               // tanh near the table end
    c.tag = 3'd2; c.v = 16'd100;
    send_cell(c);                               // lookup past the table
    c.tag = 3'd3; c.mu = 20'd0;
    send_cell(c);                               // zero viscosity
    c.tag = 3'd4; c.mu = 20'd1000; c.sg = 20'd0;
    send_cell(c);                               // zero surface tension
    c = '{3'd5, 16'd16000, 16'd16, 20'd1000, 20'd24500, 16'd200, 16'd5000, 16'hFFFF};
    send_cell(c);                               // Eo near 10: negative Cl
    c.tag = 3'd6; c.sg = 20'd61000;
    send_cell(c);                               // Eo near 4
    c = '{3'd7, 16'hFFFF, 16'hFFFF, 20'd1, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_cell(c);                               // Re clamp, zero density difference
    c = '{3'd7, 16'hFFFF, 16'd0, 20'hFFFFF, 20'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_cell(c);                               // Eo clamp, all-ones elsewhere
    c = '{3'd0, 16'd0, 16'd0, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0};
    send_cell(c);                               // all zero
    c = '{3'd2, 16'd0, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 16'd0, 16'hFFFF, 16'd0};
    send_cell(c);                               // gas heavier than liquid
  endtask

  task automatic test_gravity_extremes();
    write_gravity(24'd0);                       // Eo zero unless surface tension is zero
    for (int i = 0; i < 6; i++) send_cell(i % 2 ? bubbly_cell() : rand_cell());
    write_gravity(24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_cell(i % 2 ? bubbly_cell() : rand_cell());
  endtask

  task automatic test_random_cells();
    bit [23:0] g [4];
    g = '{blc_pkg::GRAVITY_RESET, 24'($urandom), 24'd1 << $urandom_range(0, 23),
          blc_pkg::GRAVITY_RESET};
    foreach (g[k]) begin
      write_gravity(g[k]);
      for (int i = 0; i < 125; i++) send_cell($urandom_range(0, 2) ? bubbly_cell() : rand_cell());
    end
  endtask

  initial begin
    for (int i = 0; i < (1 << blc_pkg::TANH_TABLE_BITS); i++) tanh_q12[i] = lift_tanh_q12(i);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_gravity_extremes();
    test_random_cells();
    drain();
    if (mismatches == 0 && lift_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
